// ===== hdl/sbi_pkg.sv =====
// Shared constants for the segment versus box intersection test.
// No dependencies; imported by the top level.
package sbi_pkg;

    // Default width of a segment coordinate, two's complement.
    localparam int COORD_BITS_DEFAULT = 16;
    localparam int COORD_BITS_MIN     = 8;
    localparam int COORD_BITS_MAX     = 32;

    // Width of a box corner coordinate, unsigned.
    localparam int BOX_BITS = 12;

    // Result word layout.
    localparam int RES_BITS  = 6;
    localparam int RES_TDATA = ((RES_BITS + 7) / 8) * 8;

endpackage

// ===== hdl/sbi_edge_check.sv =====
// Final decision for one box edge from its exact cross products.
// Standalone combinational logic; used by segment_box_intersection_test.
module sbi_edge_check #(
    parameter int VAL_BITS = 35
) (
    input  logic signed [VAL_BITS-1:0] cr,
    input  logic signed [VAL_BITS-1:0] cs,
    input  logic signed [VAL_BITS-1:0] den,
    input  logic                       overlap,
    output logic                       hit
);

    logic signed [VAL_BITS:0] cr_ext;
    logic signed [VAL_BITS:0] cs_ext;
    logic signed [VAL_BITS:0] den_ext;
    logic signed [VAL_BITS:0] cr_diff;
    logic signed [VAL_BITS:0] cs_diff;
    logic                     cr_zero;
    logic                     den_zero;
    logic                     den_neg;
    logic                     cr_in;
    logic                     cs_in;

    assign cr_ext  = {cr[VAL_BITS-1], cr};
    assign cs_ext  = {cs[VAL_BITS-1], cs};
    assign den_ext = {den[VAL_BITS-1], den};
    assign cr_diff = cr_ext - den_ext;
    assign cs_diff = cs_ext - den_ext;

    assign cr_zero  = (cr == '0);
    assign den_zero = (den == '0);
    assign den_neg  = den[VAL_BITS-1];

    // A value lies in the closed range from zero to den, whichever sign den has.
    always_comb begin
        if (!den_neg) begin
            cr_in = !cr[VAL_BITS-1] && (cr_diff[VAL_BITS] || (cr_diff == '0));
            cs_in = !cs[VAL_BITS-1] && (cs_diff[VAL_BITS] || (cs_diff == '0));
        end else begin
            cr_in = (cr[VAL_BITS-1] || cr_zero) && !cr_diff[VAL_BITS];
            cs_in = (cs[VAL_BITS-1] || (cs == '0)) && !cs_diff[VAL_BITS];
        end
    end

    // When the end point sits on the edge's line only the overlap test counts;
    // otherwise parallel lines never hit.
    assign hit = cr_zero ? overlap : (!den_zero && cr_in && cs_in);

endmodule

// ===== hdl/segment_box_intersection_test.sv =====
// Top level of the segment versus axis-aligned box intersection test.
// Depends on sbi_pkg and sbi_edge_check.

// Every transfer carries one segment and one box and yields exactly one result.
// The block is a four-stage pipeline: differences and the reject test, then the
// ten products, then the cross products, then the per-edge range checks into the
// output register. It takes one transfer every cycle unless back-pressure reaches the
// input. Stages hold their contents under back-pressure, and empty stages keep
// filling. An inverted box is used as given. A zero-length segment or edge can
// only hit when the end point lies on the edge's line.
module segment_box_intersection_test #(
    parameter int COORD_BITS = sbi_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    // seg_start_x, seg_start_y, seg_end_x, seg_end_y (COORD_BITS each),
    // box_min_x, box_min_y, box_max_x, box_max_y (12 bits each), zero padded
    input  logic [((4*COORD_BITS+4*sbi_pkg::BOX_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                                              s_tvalid,
    output logic                                              s_tready,
    // hits_box (1), edge_hits (4), rejected_outside (1), zero padded
    output logic [sbi_pkg::RES_TDATA-1:0]                     m_tdata,
    output logic                                              m_tvalid,
    input  logic                                              m_tready
);

    import sbi_pkg::*;

    localparam int DW  = ((COORD_BITS > BOX_BITS) ? COORD_BITS : BOX_BITS + 1) + 1;
    localparam int PDW = 2 * DW;
    localparam int VW  = PDW + 1;
    localparam int BOX_OFS = 4 * COORD_BITS;

    localparam int EDGE_TOP    = 0;
    localparam int EDGE_LEFT   = 1;
    localparam int EDGE_RIGHT  = 2;
    localparam int EDGE_BOTTOM = 3;
    localparam int EDGE_COUNT  = 4;

    // Input unpacking, all widened to DW.
    logic [COORD_BITS-1:0] in_sx, in_sy, in_ex, in_ey;
    logic [BOX_BITS-1:0]   in_x0, in_y0, in_x1, in_y1;
    logic signed [DW-1:0]  sx, sy, ex, ey, x0, y0, x1, y1;

    assign in_sx = s_tdata[COORD_BITS-1:0];
    assign in_sy = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_ex = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign in_ey = s_tdata[4*COORD_BITS-1:3*COORD_BITS];
    assign in_x0 = s_tdata[BOX_OFS+BOX_BITS-1:BOX_OFS];
    assign in_y0 = s_tdata[BOX_OFS+2*BOX_BITS-1:BOX_OFS+BOX_BITS];
    assign in_x1 = s_tdata[BOX_OFS+3*BOX_BITS-1:BOX_OFS+2*BOX_BITS];
    assign in_y1 = s_tdata[BOX_OFS+4*BOX_BITS-1:BOX_OFS+3*BOX_BITS];

    assign sx = {{(DW-COORD_BITS){in_sx[COORD_BITS-1]}}, in_sx};
    assign sy = {{(DW-COORD_BITS){in_sy[COORD_BITS-1]}}, in_sy};
    assign ex = {{(DW-COORD_BITS){in_ex[COORD_BITS-1]}}, in_ex};
    assign ey = {{(DW-COORD_BITS){in_ey[COORD_BITS-1]}}, in_ey};
    assign x0 = {{(DW-BOX_BITS){1'b0}}, in_x0};
    assign y0 = {{(DW-BOX_BITS){1'b0}}, in_y0};
    assign x1 = {{(DW-BOX_BITS){1'b0}}, in_x1};
    assign y1 = {{(DW-BOX_BITS){1'b0}}, in_y1};

    // Stage valids and the ready chain.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // Stage 1: offsets from both corners, segment direction, box extents, reject and overlap flags.
    logic signed [DW-1:0] q0x_reg, q0y_reg, q1x_reg, q1y_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, wx_reg, wy_reg;
    logic                 rej1_reg, ovx1_reg, ovy1_reg;
    logic                 rej_next, ovx_next, ovy_next;

    assign rej_next = ((sx <= x0) && (ex <= x0)) || ((sy <= y0) && (ey <= y0)) ||
                      ((sx >= x1) && (ex >= x1)) || ((sy >= y1) && (ey >= y1));
    // End point between the edge's end coordinates, per axis, lower end included, upper end excluded.
    assign ovx_next = (ex < x0) != (ex < x1);
    assign ovy_next = (ey < y0) != (ey < y1);

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            q0x_reg  <= ex - x0;
            q0y_reg  <= ey - y0;
            q1x_reg  <= ex - x1;
            q1y_reg  <= ey - y1;
            dx_reg   <= sx - ex;
            dy_reg   <= sy - ey;
            wx_reg   <= x1 - x0;
            wy_reg   <= y1 - y0;
            rej1_reg <= rej_next;
            ovx1_reg <= ovx_next;
            ovy1_reg <= ovy_next;
        end
    end

    // Stage 2: the distinct products needed by the top, left, right and bottom edge tests.
    logic signed [PDW-1:0] p_q0x_dy_reg, p_q0y_dx_reg, p_q1x_dy_reg, p_q1y_dx_reg;
    logic signed [PDW-1:0] p_q0y_wx_reg, p_q0x_wy_reg, p_q1x_wy_reg, p_q1y_wx_reg;
    logic signed [PDW-1:0] p_wx_dy_reg, p_wy_dx_reg;
    logic                  rej2_reg, ovx2_reg, ovy2_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            p_q0x_dy_reg <= q0x_reg * dy_reg;
            p_q0y_dx_reg <= q0y_reg * dx_reg;
            p_q1x_dy_reg <= q1x_reg * dy_reg;
            p_q1y_dx_reg <= q1y_reg * dx_reg;
            p_q0y_wx_reg <= q0y_reg * wx_reg;
            p_q0x_wy_reg <= q0x_reg * wy_reg;
            p_q1x_wy_reg <= q1x_reg * wy_reg;
            p_q1y_wx_reg <= q1y_reg * wx_reg;
            p_wx_dy_reg  <= wx_reg * dy_reg;
            p_wy_dx_reg  <= wy_reg * dx_reg;
            rej2_reg     <= rej1_reg;
            ovx2_reg     <= ovx1_reg;
            ovy2_reg     <= ovy1_reg;
        end
    end

    // Stage 3: cross products per edge. Top and left share the first corner,
    // right and bottom the second, so each pair shares one cs term.
    function automatic logic signed [VW-1:0] widen(input logic signed [PDW-1:0] p);
        widen = {p[PDW-1], p};
    endfunction

    logic signed [VW-1:0] cr_reg [EDGE_COUNT];
    logic signed [VW-1:0] den_reg[EDGE_COUNT];
    logic signed [VW-1:0] cs0_reg, cs1_reg;
    logic                 rej3_reg, ovx3_reg, ovy3_reg;

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            cs0_reg              <= widen(p_q0x_dy_reg) - widen(p_q0y_dx_reg);
            cs1_reg              <= widen(p_q1x_dy_reg) - widen(p_q1y_dx_reg);
            cr_reg[EDGE_TOP]     <= -widen(p_q0y_wx_reg);
            cr_reg[EDGE_LEFT]    <= widen(p_q0x_wy_reg);
            cr_reg[EDGE_RIGHT]   <= -widen(p_q1x_wy_reg);
            cr_reg[EDGE_BOTTOM]  <= widen(p_q1y_wx_reg);
            den_reg[EDGE_TOP]    <= widen(p_wx_dy_reg);
            den_reg[EDGE_LEFT]   <= -widen(p_wy_dx_reg);
            den_reg[EDGE_RIGHT]  <= widen(p_wy_dx_reg);
            den_reg[EDGE_BOTTOM] <= -widen(p_wx_dy_reg);
            rej3_reg             <= rej2_reg;
            ovx3_reg             <= ovx2_reg;
            ovy3_reg             <= ovy2_reg;
        end
    end

    // Stage 4: range checks and the result register.
    logic [EDGE_COUNT-1:0] edge_hit;
    logic [EDGE_COUNT-1:0] mask_next;
    logic [EDGE_COUNT-1:0] mask_reg;
    logic                  rej4_reg;

    sbi_edge_check #(.VAL_BITS(VW)) u_top (
        .cr(cr_reg[EDGE_TOP]), .cs(cs0_reg), .den(den_reg[EDGE_TOP]),
        .overlap(ovx3_reg), .hit(edge_hit[EDGE_TOP])
    );

    sbi_edge_check #(.VAL_BITS(VW)) u_left (
        .cr(cr_reg[EDGE_LEFT]), .cs(cs0_reg), .den(den_reg[EDGE_LEFT]),
        .overlap(ovy3_reg), .hit(edge_hit[EDGE_LEFT])
    );

    sbi_edge_check #(.VAL_BITS(VW)) u_right (
        .cr(cr_reg[EDGE_RIGHT]), .cs(cs1_reg), .den(den_reg[EDGE_RIGHT]),
        .overlap(ovy3_reg), .hit(edge_hit[EDGE_RIGHT])
    );

    sbi_edge_check #(.VAL_BITS(VW)) u_bottom (
        .cr(cr_reg[EDGE_BOTTOM]), .cs(cs1_reg), .den(den_reg[EDGE_BOTTOM]),
        .overlap(ovx3_reg), .hit(edge_hit[EDGE_BOTTOM])
    );

    assign mask_next = rej3_reg ? '0 : edge_hit;

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            mask_reg <= mask_next;
            rej4_reg <= rej3_reg;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {{(RES_TDATA-RES_BITS){1'b0}}, rej4_reg, mask_reg, |mask_reg};

    // A rejected pair never reports an edge.
    assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg && rej4_reg |-> mask_reg == '0)
        else $error("edge hits reported for a rejected pair");

    // The input only stalls when every stage is occupied.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> v1_reg && v2_reg && v3_reg && v4_reg)
        else $error("input stalled with an empty stage");

    // An item leaving stage one always lands in stage two.
    assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && rdy2 |=> v2_reg)
        else $error("item lost between stage one and stage two");

    // A stalled result keeps its content.
    assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg && !rdy4 |=> $stable(mask_reg) && $stable(rej4_reg))
        else $error("result register changed while stalled");

endmodule

// ===== tb/segment_box_intersection_test_test.sv =====
// Self-checking testbench for segment_box_intersection_test: directed and random
// segment/box pairs, random idling on both streams, exact integer prediction.
// Depends on sbi_pkg and the segment_box_intersection_test RTL.
module segment_box_intersection_test_test;
    import sbi_pkg::*;

    localparam int CB        = COORD_BITS_DEFAULT;
    localparam int IN_W      = ((4 * CB + 4 * BOX_BITS + 7) / 8) * 8;
    localparam int LIMIT     = 400000;
    localparam int N_RANDOM  = 500;
    localparam int LONG_HOLD = 80;

    typedef struct {
        logic signed [CB-1:0]       sx;
        logic signed [CB-1:0]       sy;
        logic signed [CB-1:0]       ex;
        logic signed [CB-1:0]       ey;
        logic        [BOX_BITS-1:0] x0;
        logic        [BOX_BITS-1:0] y0;
        logic        [BOX_BITS-1:0] x1;
        logic        [BOX_BITS-1:0] y1;
    } pair_t;

    typedef struct {
        bit       hits_box;
        bit [3:0] edge_hits;
        bit       rejected_outside;
    } hit_word_t;

    // Holds the predicted hit words of accepted pairs, oldest first.
    class hit_ledger;
        hit_word_t awaited_hits[$];
        int errors;
        int noted;

        function bit in_span(longint v, longint den);
            if (den > 0)
                return v >= 0 && v <= den;
            return v <= 0 && v >= den;
        endfunction

        // Side from A to B against the segment from C (end) to D (start).
        function bit crosses_side(longint ax, longint ay, longint bx, longint by,
                                  longint cx, longint cy, longint dx, longint dy);
            longint qx, qy, rx, ry, sx, sy, cr, cs, den;
            qx = cx - ax;
            qy = cy - ay;
            rx = bx - ax;
            ry = by - ay;
            sx = dx - cx;
            sy = dy - cy;
            cr = qx * ry - qy * rx;
            cs = qx * sy - qy * sx;
            den = rx * sy - ry * sx;
            // End point on the side's line: it counts only if it lies between the side's ends (lower end included).
            if (cr == 0)
                return ((cx < ax) != (cx < bx)) || ((cy < ay) != (cy < by));
            if (den == 0)
                return 1'b0;
            return in_span(cs, den) && in_span(cr, den);
        endfunction

        function hit_word_t predict_hits(pair_t p);
            hit_word_t r;
            longint sx, sy, ex, ey, x0, y0, x1, y1;
            sx = longint'(p.sx);
            sy = longint'(p.sy);
            ex = longint'(p.ex);
            ey = longint'(p.ey);
            x0 = longint'(p.x0);
            y0 = longint'(p.y0);
            x1 = longint'(p.x1);
            y1 = longint'(p.y1);
            r.rejected_outside = (sx <= x0 && ex <= x0) || (sy <= y0 && ey <= y0) ||
                                 (sx >= x1 && ex >= x1) || (sy >= y1 && ey >= y1);
            r.edge_hits = '0;
            if (!r.rejected_outside) begin
                r.edge_hits[0] = crosses_side(x0, y0, x1, y0, ex, ey, sx, sy);
                r.edge_hits[1] = crosses_side(x0, y0, x0, y1, ex, ey, sx, sy);
                r.edge_hits[2] = crosses_side(x1, y1, x1, y0, ex, ey, sx, sy);
                r.edge_hits[3] = crosses_side(x1, y1, x0, y1, ex, ey, sx, sy);
            end
            r.hits_box = |r.edge_hits;
            return r;
        endfunction

        function void note_pair(pair_t p);
            awaited_hits.push_back(predict_hits(p));
            noted++;
        endfunction

        function void check_hit_word(logic [RES_TDATA-1:0] w);
            hit_word_t want;
            if (awaited_hits.size() == 0) begin
                $error("result transfer 0x%h arrived with nothing pending", w);
                errors++;
                return;
            end
            want = awaited_hits.pop_front();
            if (w[0] !== want.hits_box) begin
                $error("hits_box: expected %0d, got %0d", want.hits_box, w[0]);
                errors++;
            end
            if (w[4:1] !== want.edge_hits) begin
                $error("edge_hits: expected %b, got %b", want.edge_hits, w[4:1]);
                errors++;
            end
            if (w[5] !== want.rejected_outside) begin
                $error("rejected_outside: expected %0d, got %0d",
                       want.rejected_outside, w[5]);
                errors++;
            end
        endfunction

        function int pending();
            return awaited_hits.size();
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic [IN_W-1:0]      s_tdata  = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [RES_TDATA-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;

    hit_ledger ledger = new();
    bit sender_calm = 1'b0;
    int cycles = 0;

    segment_box_intersection_test #(
        .COORD_BITS(CB)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [IN_W-1:0] pack_pair(pair_t p);
        return IN_W'({p.y1, p.x1, p.y0, p.x0, p.ey, p.ex, p.sy, p.sx});
    endfunction

    // A coordinate somewhat around the span between a and b, snapped to a or b now and then.
    function automatic int coord_near(int a, int b);
        int lo, hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? a : b;
        return lo - 300 + int'($urandom_range(0, hi - lo + 600));
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        int kind, x0, y0, x1, y1, sx, sy, ex, ey;
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            p.sx = CB'($urandom);
            p.sy = CB'($urandom);
            p.ex = CB'($urandom);
            p.ey = CB'($urandom);
            p.x0 = BOX_BITS'($urandom);
            p.y0 = BOX_BITS'($urandom);
            p.x1 = BOX_BITS'($urandom);
            p.y1 = BOX_BITS'($urandom);
            return p;
        end
        x0 = $urandom_range(0, 4095);
        y0 = $urandom_range(0, 4095);
        if (kind < 20) begin
            // Any corner order, inverted boxes included.
            x1 = $urandom_range(0, 4095);
            y1 = $urandom_range(0, 4095);
        end else begin
            x1 = x0 + $urandom_range(0, 500);
            y1 = y0 + $urandom_range(0, 500);
            if (x1 > 4095)
                x1 = 4095;
            if (y1 > 4095)
                y1 = 4095;
        end
        sx = coord_near(x0, x1);
        sy = coord_near(y0, y1);
        ex = coord_near(x0, x1);
        ey = coord_near(y0, y1);
        kind = $urandom_range(0, 99);
        if (kind < 4) begin
            ex = sx;
            ey = sy;
        end else if (kind < 14) begin
            ey = sy;
        end else if (kind < 24) begin
            ex = sx;
        end
        p.sx = CB'(sx);
        p.sy = CB'(sy);
        p.ex = CB'(ex);
        p.ey = CB'(ey);
        p.x0 = BOX_BITS'(x0);
        p.y0 = BOX_BITS'(y0);
        p.x1 = BOX_BITS'(x1);
        p.y1 = BOX_BITS'(y1);
        return p;
    endfunction

    task automatic send_pair(input pair_t p);
        int gap;
        s_tdata  <= pack_pair(p);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        ledger.note_pair(p);
        gap = sender_calm ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_coords(input int sx, input int sy, input int ex, input int ey,
                               input int x0, input int y0, input int x1, input int y1);
        pair_t p;
        p.sx = CB'(sx);
        p.sy = CB'(sy);
        p.ex = CB'(ex);
        p.ey = CB'(ey);
        p.x0 = BOX_BITS'(x0);
        p.y0 = BOX_BITS'(y0);
        p.x1 = BOX_BITS'(x1);
        p.y1 = BOX_BITS'(y1);
        send_pair(p);
    endtask

    // Every accepted result transfer is checked against the oldest prediction.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                ledger.check_hit_word(m_tdata);
        end
    end

    // Receiver: random stalls, calm stretches, and one long hold-off that backs
    // the pipeline up into the input.
    initial begin
        bit held;
        int run, gap;
        held = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && ledger.noted >= 250) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                held = 1'b1;
            end else begin
                run = $urandom_range(1, 20);
                m_tready <= 1'b1;
                repeat (run) @(posedge aclk);
                gap = ($urandom_range(0, 3) == 0) ? 0 : idle_len();
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    initial begin
        while (cycles < LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Field extremes.
        send_coords(-32768, -32768, 32767, 32767, 0, 0, 4095, 4095);
        send_coords(32767, 32767, -32768, -32768, 4095, 4095, 0, 0);
        send_coords(0, 0, 0, 0, 0, 0, 0, 0);
        send_coords(-32768, 150, 32767, 150, 100, 100, 200, 200);
        send_coords(150, 32767, 150, -32768, 100, 100, 200, 200);
        // Rejected beyond each side.
        send_coords(50, 120, 100, 180, 100, 100, 200, 200);
        send_coords(120, 40, 180, 100, 100, 100, 200, 200);
        send_coords(200, 120, 260, 180, 100, 100, 200, 200);
        send_coords(120, 200, 180, 300, 100, 100, 200, 200);
        // One crossing per side, then top and bottom together.
        send_coords(150, 150, 150, 50, 100, 100, 200, 200);
        send_coords(150, 150, 50, 150, 100, 100, 200, 200);
        send_coords(150, 150, 250, 150, 100, 100, 200, 200);
        send_coords(150, 150, 150, 250, 100, 100, 200, 200);
        send_coords(150, 50, 150, 250, 100, 100, 200, 200);
        // Fully inside, and a diagonal through two corners.
        send_coords(120, 120, 180, 180, 100, 100, 200, 200);
        send_coords(50, 50, 250, 250, 100, 100, 200, 200);
        // End point on a side's line and on a corner.
        send_coords(150, 150, 150, 100, 100, 100, 200, 200);
        send_coords(150, 150, 100, 100, 100, 100, 200, 200);
        send_coords(150, 150, 100, 250, 100, 100, 200, 200);
        // Inverted box, zero-length segment, zero-width box.
        send_coords(150, 50, 150, 250, 200, 200, 100, 100);
        send_coords(150, 150, 150, 150, 100, 100, 200, 200);
        send_coords(50, 150, 150, 150, 100, 100, 100, 200);
        send_coords(100, 120, 100, 180, 100, 100, 100, 200);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 40 == 0)
                sender_calm = ($urandom_range(0, 3) == 0);
            send_pair(random_pair());
        end
        s_tvalid <= 1'b0;

        while (ledger.pending() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
        if (ledger.errors == 0 && ledger.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/sbi_pkg.sv
hdl/sbi_edge_check.sv
hdl/segment_box_intersection_test.sv
tb/segment_box_intersection_test_test.sv
